[sv/tpcc_pkg.sv]
// Shared constants for the two-point circle centers block.
package tpcc_pkg;

	localparam int COORD_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF = 16;
	localparam int RADIUS_W = 31;
	localparam logic [RADIUS_W-1:0] RADIUS_RESET = 31'd65536;

endpackage

[sv/tpcc_if.sv]
// Point-pair request channel and center result channel.
interface tpcc_pt_if #(
	parameter int COORD_WIDTH = tpcc_pkg::COORD_WIDTH_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] first_x;
	logic signed [COORD_WIDTH-1:0] first_y;
	logic signed [COORD_WIDTH-1:0] second_x;
	logic signed [COORD_WIDTH-1:0] second_y;

	modport source (output valid, first_x, first_y, second_x, second_y, input ready);
	modport sink (input valid, first_x, first_y, second_x, second_y, output ready);
endinterface

interface tpcc_ctr_if #(
	parameter int COORD_WIDTH = tpcc_pkg::COORD_WIDTH_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] center_one_x;
	logic signed [COORD_WIDTH-1:0] center_one_y;
	logic signed [COORD_WIDTH-1:0] center_two_x;
	logic signed [COORD_WIDTH-1:0] center_two_y;
	logic                          centers_valid;

	modport source (output valid, center_one_x, center_one_y, center_two_x, center_two_y,
		centers_valid, input ready);
	modport sink (input valid, center_one_x, center_one_y, center_two_x, center_two_y,
		centers_valid, output ready);
endinterface

[sv/tpcc_front.sv]
// Front stages: differences, squares, squared distance and the numerator |4r^2 - d2|.
module tpcc_front #(
	parameter int COORD_WIDTH = tpcc_pkg::COORD_WIDTH_DEF,
	parameter int FRAC_BITS = tpcc_pkg::FRAC_BITS_DEF,
	localparam int CW = COORD_WIDTH,
	localparam int DW = CW + 1,
	localparam int D2_W = 2 * CW + 1,
	localparam int R2_W = 2 * tpcc_pkg::RADIUS_W + 2,
	localparam int N_W = (D2_W > R2_W) ? D2_W : R2_W,
	localparam int NUM_W = N_W + 2 * FRAC_BITS,
	localparam int SIDE_W = 1 + 2 * DW + 2 * DW
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                adv,
	input  logic                                in_valid,
	input  logic signed [COORD_WIDTH-1:0]       x1,
	input  logic signed [COORD_WIDTH-1:0]       y1,
	input  logic signed [COORD_WIDTH-1:0]       x2,
	input  logic signed [COORD_WIDTH-1:0]       y2,
	input  logic [tpcc_pkg::RADIUS_W-1:0]       radius,
	output logic                                out_valid,
	output logic [NUM_W-1:0]                    num,
	output logic [D2_W-1:0]                     den,
	output logic [SIDE_W-1:0]                   side
);
	// stage 1
	logic                 v_s1;
	logic [SIDE_W-1:0]    side_s1;
	logic signed [DW-1:0] dx_c, dy_c, sx_c, sy_c;

	assign dx_c = {x1[CW-1], x1} - {x2[CW-1], x2};
	assign dy_c = {y1[CW-1], y1} - {y2[CW-1], y2};
	assign sx_c = {x1[CW-1], x1} + {x2[CW-1], x2};
	assign sy_c = {y1[CW-1], y1} + {y2[CW-1], y2};

	// stage 2
	logic                                  v_s2;
	logic [SIDE_W-1:0]                     side_s2;
	logic [2*CW-1:0]                       sqx_s2, sqy_s2;
	logic [2*tpcc_pkg::RADIUS_W-1:0]       r2_s2;
	logic signed [DW-1:0]                  dx1, dy1, ndx1, ndy1;
	logic [CW-1:0]                         adx_c, ady_c;

	assign dx1 = side_s1[4*DW-1:3*DW];
	assign dy1 = side_s1[3*DW-1:2*DW];
	assign ndx1 = -dx1;
	assign ndy1 = -dy1;
	assign adx_c = dx1[DW-1] ? ndx1[CW-1:0] : dx1[CW-1:0];
	assign ady_c = dy1[DW-1] ? ndy1[CW-1:0] : dy1[CW-1:0];

	// stage 3
	logic              v_s3;
	logic [SIDE_W-1:0] side_s3;
	logic [D2_W-1:0]   d2_s3;
	logic [R2_W-1:0]   fr2_s3;

	// stage 4
	logic              v_s4;
	logic [SIDE_W-1:0] side_s4;
	logic [N_W-1:0]    n_s4;
	logic [D2_W-1:0]   den_s4;
	logic [N_W-1:0]    fr2e, d2e;

	assign fr2e = N_W'(fr2_s3);
	assign d2e = N_W'(d2_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s1 <= {(x1 == x2) && (y1 == y2), dx_c, dy_c, sx_c, sy_c};
			side_s2 <= side_s1;
			sqx_s2 <= adx_c * adx_c;
			sqy_s2 <= ady_c * ady_c;
			r2_s2 <= radius * radius;
			side_s3 <= side_s2;
			d2_s3 <= D2_W'(sqx_s2) + D2_W'(sqy_s2);
			fr2_s3 <= {r2_s2, 2'b00};
			side_s4 <= side_s3;
			n_s4 <= (fr2e >= d2e) ? (fr2e - d2e) : (d2e - fr2e);
			// keep the divider away from zero on coincident points
			den_s4 <= side_s3[SIDE_W-1] ? D2_W'(1) : d2_s3;
		end
	end

	assign out_valid = v_s4;
	assign num = {n_s4, {(2 * FRAC_BITS){1'b0}}};
	assign den = den_s4;
	assign side = side_s4;
endmodule

[sv/tpcc_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
module tpcc_div #(
	parameter int NUM_W = 97,
	parameter int DEN_W = 65,
	parameter int SIDE_W = 133
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              in_valid,
	input  logic [NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]  den,
	input  logic [SIDE_W-1:0] side,
	output logic              out_valid,
	output logic [NUM_W-1:0]  quo,
	output logic [SIDE_W-1:0] out_side
);
	logic              v_s    [1:NUM_W];
	logic [NUM_W-1:0]  nq_s   [1:NUM_W];
	logic [DEN_W-1:0]  rem_s  [1:NUM_W];
	logic [DEN_W-1:0]  den_s  [1:NUM_W];
	logic [SIDE_W-1:0] side_s [1:NUM_W];

	genvar i;
	for (i = 0; i < NUM_W; i++) begin : g_stg
		logic              v_c;
		logic [NUM_W-1:0]  nq_c;
		logic [DEN_W-1:0]  rem_c, den_c;
		logic [SIDE_W-1:0] side_c;
		logic [DEN_W:0]    sh, dif;
		logic              ge;

		if (i == 0) begin : g_first
			assign v_c = in_valid;
			assign nq_c = num;
			assign rem_c = '0;
			assign den_c = den;
			assign side_c = side;
		end else begin : g_next
			assign v_c = v_s[i];
			assign nq_c = nq_s[i];
			assign rem_c = rem_s[i];
			assign den_c = den_s[i];
			assign side_c = side_s[i];
		end

		// shift in the next dividend bit, subtract when it fits
		assign sh = {rem_c, nq_c[NUM_W-1]};
		assign ge = sh >= {1'b0, den_c};
		assign dif = sh - {1'b0, den_c};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (adv) begin
				v_s[i+1] <= v_c;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				nq_s[i+1] <= {nq_c[NUM_W-2:0], ge};
				rem_s[i+1] <= ge ? dif[DEN_W-1:0] : sh[DEN_W-1:0];
				den_s[i+1] <= den_c;
				side_s[i+1] <= side_c;
			end
		end
	end

	assign out_valid = v_s[NUM_W];
	assign quo = nq_s[NUM_W];
	assign out_side = side_s[NUM_W];
endmodule

[sv/tpcc_sqrt.sv]
// Pipelined digit-by-digit square root, one root bit per stage.
module tpcc_sqrt #(
	parameter int IN_W = 97,
	parameter int SIDE_W = 133,
	localparam int ROOT_W = (IN_W + 1) / 2,
	localparam int PAD_W = 2 * ROOT_W
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               in_valid,
	input  logic [IN_W-1:0]    val,
	input  logic [SIDE_W-1:0]  side,
	output logic               out_valid,
	output logic [ROOT_W-1:0]  root,
	output logic [SIDE_W-1:0]  out_side
);
	logic              v_s    [1:ROOT_W];
	logic [PAD_W-1:0]  val_s  [1:ROOT_W];
	logic [ROOT_W:0]   rem_s  [1:ROOT_W];
	logic [ROOT_W-1:0] root_s [1:ROOT_W];
	logic [SIDE_W-1:0] side_s [1:ROOT_W];

	genvar j;
	for (j = 0; j < ROOT_W; j++) begin : g_stg
		logic              v_c;
		logic [PAD_W-1:0]  val_c;
		logic [ROOT_W:0]   rem_c;
		logic [ROOT_W-1:0] root_c;
		logic [SIDE_W-1:0] side_c;
		logic [ROOT_W+2:0] sh, trial, dif;
		logic              ge;

		if (j == 0) begin : g_first
			assign v_c = in_valid;
			assign val_c = PAD_W'(val);
			assign rem_c = '0;
			assign root_c = '0;
			assign side_c = side;
		end else begin : g_next
			assign v_c = v_s[j];
			assign val_c = val_s[j];
			assign rem_c = rem_s[j];
			assign root_c = root_s[j];
			assign side_c = side_s[j];
		end

		// bring down two radicand bits, try root*4+1
		assign sh = {rem_c, val_c[PAD_W-1:PAD_W-2]};
		assign trial = {1'b0, root_c, 2'b01};
		assign ge = sh >= trial;
		assign dif = sh - trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j+1] <= 1'b0;
			end else if (adv) begin
				v_s[j+1] <= v_c;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				val_s[j+1] <= {val_c[PAD_W-3:0], 2'b00};
				rem_s[j+1] <= ge ? dif[ROOT_W:0] : sh[ROOT_W:0];
				root_s[j+1] <= {root_c[ROOT_W-2:0], ge};
				side_s[j+1] <= side_c;
			end
		end
	end

	assign out_valid = v_s[ROOT_W];
	assign root = root_s[ROOT_W];
	assign out_side = side_s[ROOT_W];
endmodule

[sv/tpcc_back.sv]
// Back stages: offset products, midpoint sums, halving and saturation.
module tpcc_back #(
	parameter int COORD_WIDTH = tpcc_pkg::COORD_WIDTH_DEF,
	parameter int FRAC_BITS = tpcc_pkg::FRAC_BITS_DEF,
	parameter int ROOT_W = 49,
	localparam int CW = COORD_WIDTH,
	localparam int DW = CW + 1,
	localparam int SIDE_W = 1 + 4 * DW,
	localparam int LO_W = (ROOT_W + 1) / 2,
	localparam int HI_W = ROOT_W - LO_W,
	localparam int PL_W = DW + LO_W + 1,
	localparam int PH_W = DW + HI_W + 1,
	localparam int PX_W = DW + ROOT_W + 1,
	localparam int MX_W = DW + FRAC_BITS,
	localparam int SUM_W = ((PX_W > MX_W) ? PX_W : MX_W) + 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic                          in_valid,
	input  logic [ROOT_W-1:0]             root,
	input  logic [SIDE_W-1:0]             side,
	output logic                          out_valid,
	output logic signed [COORD_WIDTH-1:0] c1x,
	output logic signed [COORD_WIDTH-1:0] c1y,
	output logic signed [COORD_WIDTH-1:0] c2x,
	output logic signed [COORD_WIDTH-1:0] c2y,
	output logic                          cv
);
	function automatic logic [CW-1:0] sat(input logic signed [SUM_W-1:0] s);
		logic signed [SUM_W-1:0] t, hi, lo;
		begin
			t = s >>> (FRAC_BITS + 1);
			hi = $signed({{(SUM_W - CW + 1){1'b0}}, {(CW - 1){1'b1}}});
			lo = ~hi;
			if (t > hi) begin
				sat = hi[CW-1:0];
			end else if (t < lo) begin
				sat = lo[CW-1:0];
			end else begin
				sat = t[CW-1:0];
			end
		end
	endfunction

	logic                 coin_c;
	logic signed [DW-1:0] dx_c, dy_c, sx_c, sy_c;
	logic signed [LO_W:0] rlo_c;
	logic signed [HI_W:0] rhi_c;

	assign {coin_c, dx_c, dy_c, sx_c, sy_c} = side;
	assign rlo_c = $signed({1'b0, root[LO_W-1:0]});
	assign rhi_c = $signed({1'b0, root[ROOT_W-1:LO_W]});

	// stage 1: partial products of the offsets
	logic                   v_s1, coin_s1;
	logic signed [PL_W-1:0] pxl_s1, pyl_s1;
	logic signed [PH_W-1:0] pxh_s1, pyh_s1;
	logic signed [DW-1:0]   sx_s1, sy_s1;

	// stage 2: full offsets and scaled midpoint sums
	logic                   v_s2, coin_s2;
	logic signed [PX_W-1:0] px_s2, py_s2;
	logic signed [MX_W-1:0] mx_s2, my_s2;

	// stage 3: output register
	logic                   v_s3, cv_s3;
	logic signed [CW-1:0]   c1x_s3, c1y_s3, c2x_s3, c2y_s3;

	logic signed [SUM_W-1:0] mxe, mye, pxe, pye;

	assign mxe = SUM_W'(mx_s2);
	assign mye = SUM_W'(my_s2);
	assign pxe = SUM_W'(px_s2);
	assign pye = SUM_W'(py_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pxl_s1 <= dx_c * rlo_c;
			pxh_s1 <= dx_c * rhi_c;
			pyl_s1 <= dy_c * rlo_c;
			pyh_s1 <= dy_c * rhi_c;
			sx_s1 <= sx_c;
			sy_s1 <= sy_c;
			coin_s1 <= coin_c;

			px_s2 <= (PX_W'(pxh_s1) <<< LO_W) + PX_W'(pxl_s1);
			py_s2 <= (PX_W'(pyh_s1) <<< LO_W) + PX_W'(pyl_s1);
			mx_s2 <= MX_W'(sx_s1) <<< FRAC_BITS;
			my_s2 <= MX_W'(sy_s1) <<< FRAC_BITS;
			coin_s2 <= coin_s1;

			// coincident points give zero centers
			c1x_s3 <= coin_s2 ? '0 : sat(mxe + pye);
			c1y_s3 <= coin_s2 ? '0 : sat(mye - pxe);
			c2x_s3 <= coin_s2 ? '0 : sat(mxe - pye);
			c2y_s3 <= coin_s2 ? '0 : sat(mye + pxe);
			cv_s3 <= ~coin_s2;
		end
	end

	assign out_valid = v_s3;
	assign c1x = c1x_s3;
	assign c1y = c1y_s3;
	assign c2x = c2x_s3;
	assign c2y = c2y_s3;
	assign cv = cv_s3;
endmodule

[sv/two_point_circle_centers_core.sv]
// Top level of the two-point circle centers block.
//
// Channels: pts carries one request per pair of points (first_x, first_y,
// second_x, second_y, signed fixed point with FRAC_BITS fraction bits);
// ctrs returns one result per request, in order: the two centers of the
// circles of the configured radius through both points, plus centers_valid,
// which is low (and the centers zero) when the two points coincide.
// cfg_wen/cfg_wdata write the radius (unsigned, same fraction bits); write
// it only while no request is in flight.
// Throughput: one request per cycle while no finished result is held on
// ctrs with ready low. Requests pass the front stages, the bit-per-stage
// divider (NUM_W stages), square root (ROOT_W stages) and back stages.
// Reset: clears every stage valid bit, so the pipe comes up empty, and
// loads the radius with 1.0.
// Stall: when a result waits on ctrs with ready low, the whole pipe holds
// and pts.ready drops; no request is lost or repeated.
module two_point_circle_centers_core #(
	parameter int COORD_WIDTH = tpcc_pkg::COORD_WIDTH_DEF,
	parameter int FRAC_BITS = tpcc_pkg::FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	tpcc_pt_if.sink                         pts,
	tpcc_ctr_if.source                      ctrs,
	input  logic                            cfg_wen,
	input  logic [tpcc_pkg::RADIUS_W-1:0]   cfg_wdata
);
	localparam int DW = COORD_WIDTH + 1;
	localparam int D2_W = 2 * COORD_WIDTH + 1;
	localparam int R2_W = 2 * tpcc_pkg::RADIUS_W + 2;
	localparam int N_W = (D2_W > R2_W) ? D2_W : R2_W;
	localparam int NUM_W = N_W + 2 * FRAC_BITS;
	localparam int ROOT_W = (NUM_W + 1) / 2;
	localparam int SIDE_W = 1 + 4 * DW;

	logic [tpcc_pkg::RADIUS_W-1:0] radius_q;

	// advance every stage unless a finished result is held
	logic adv;
	logic back_valid;

	assign adv = ~back_valid | ctrs.ready;
	assign pts.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= tpcc_pkg::RADIUS_RESET;
		end else if (cfg_wen) begin
			radius_q <= cfg_wdata;
		end
	end

	logic              f_valid;
	logic [NUM_W-1:0]  f_num;
	logic [D2_W-1:0]   f_den;
	logic [SIDE_W-1:0] f_side;

	tpcc_front #(
		.COORD_WIDTH (COORD_WIDTH),
		.FRAC_BITS   (FRAC_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (pts.valid),
		.x1        (pts.first_x),
		.y1        (pts.first_y),
		.x2        (pts.second_x),
		.y2        (pts.second_y),
		.radius    (radius_q),
		.out_valid (f_valid),
		.num       (f_num),
		.den       (f_den),
		.side      (f_side)
	);

	// quotient = floor(N * 2^(2*FRAC_BITS) / d2)
	logic              d_valid;
	logic [NUM_W-1:0]  d_quo;
	logic [SIDE_W-1:0] d_side;

	tpcc_div #(
		.NUM_W  (NUM_W),
		.DEN_W  (D2_W),
		.SIDE_W (SIDE_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (f_valid),
		.num       (f_num),
		.den       (f_den),
		.side      (f_side),
		.out_valid (d_valid),
		.quo       (d_quo),
		.out_side  (d_side)
	);

	// offset factor root = floor(sqrt(quotient))
	logic              s_valid;
	logic [ROOT_W-1:0] s_root;
	logic [SIDE_W-1:0] s_side;

	tpcc_sqrt #(
		.IN_W   (NUM_W),
		.SIDE_W (SIDE_W)
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (d_valid),
		.val       (d_quo),
		.side      (d_side),
		.out_valid (s_valid),
		.root      (s_root),
		.out_side  (s_side)
	);

	tpcc_back #(
		.COORD_WIDTH (COORD_WIDTH),
		.FRAC_BITS   (FRAC_BITS),
		.ROOT_W      (ROOT_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (s_valid),
		.root      (s_root),
		.side      (s_side),
		.out_valid (back_valid),
		.c1x       (ctrs.center_one_x),
		.c1y       (ctrs.center_one_y),
		.c2x       (ctrs.center_two_x),
		.c2y       (ctrs.center_two_y),
		.cv        (ctrs.centers_valid)
	);

	assign ctrs.valid = back_valid;
endmodule
